FILE: src/lfc_pkg.sv
// shared constants and types of the loopback frame checker
package lfc_pkg;

	localparam int unsigned WORD_W          = 32;
	localparam int unsigned SEQ_W           = 64;
	localparam int unsigned TOTAL_W         = 64;
	localparam int unsigned POS_W           = 10;
	localparam int unsigned MAX_FRAME_WORDS = 512;

	localparam logic [POS_W-1:0] POS_LIMIT  = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(0);
	localparam logic [POS_W-1:0] POS_CSUM   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_SEQ_LO = POS_W'(2);
	localparam logic [POS_W-1:0] POS_SEQ_HI = POS_W'(3);

	// per-frame verdict handed from the accumulator to the totals logic
	typedef struct packed {
		logic              checksum_bad;
		logic [WORD_W-1:0] frame_length;
		logic [SEQ_W-1:0]  received_sequence;
	} frame_rpt_t;

endpackage

FILE: src/lfc_word_if.sv
// item channels: received words in, per-frame reports out
interface lfc_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        frame_end;

	modport source (output valid, output data_word, output frame_end, input ready);
	modport sink   (input valid, input data_word, input frame_end, output ready);
endinterface

interface lfc_report_if;
	logic        valid;
	logic        ready;
	logic        checksum_bad;
	logic        sequence_bad;
	logic [31:0] frame_length;
	logic [63:0] received_sequence;
	logic [63:0] checksum_error_total;
	logic [63:0] sequence_error_total;
	logic [63:0] good_words_total;

	modport source (
		output valid, output checksum_bad, output sequence_bad, output frame_length,
		output received_sequence, output checksum_error_total,
		output sequence_error_total, output good_words_total,
		input ready
	);
	modport sink (
		input valid, input checksum_bad, input sequence_bad, input frame_length,
		input received_sequence, input checksum_error_total,
		input sequence_error_total, input good_words_total,
		output ready
	);
endinterface

FILE: src/lfc_frame_acc.sv
// per-frame header capture and add-xor checksum accumulation
module lfc_frame_acc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [lfc_pkg::WORD_W-1:0]          data_word,
	input  logic                                frame_end,
	output lfc_pkg::frame_rpt_t                 rpt
);

	logic [lfc_pkg::POS_W-1:0]  pos_q;
	logic [lfc_pkg::WORD_W-1:0] sum_q;
	logic [lfc_pkg::WORD_W-1:0] len_q;
	logic [lfc_pkg::WORD_W-1:0] carried_q;
	logic [lfc_pkg::SEQ_W-1:0]  seq_q;

	logic [lfc_pkg::WORD_W-1:0] len_d;
	logic [lfc_pkg::WORD_W-1:0] carried_d;
	logic [lfc_pkg::SEQ_W-1:0]  seq_d;
	logic [lfc_pkg::WORD_W-1:0] sum_d;
	logic [lfc_pkg::WORD_W-1:0] term;
	logic [lfc_pkg::WORD_W-1:0] pos_ext;
	logic [lfc_pkg::WORD_W-1:0] received;
	logic                       too_long;
	logic                       too_short;

	always_comb begin
		len_d     = (pos_q == lfc_pkg::POS_LENGTH) ? data_word : len_q;
		carried_d = (pos_q == lfc_pkg::POS_CSUM) ? data_word : carried_q;
		seq_d     = seq_q;
		if (pos_q == lfc_pkg::POS_SEQ_LO) begin
			seq_d[31:0] = data_word;
		end else if (pos_q == lfc_pkg::POS_SEQ_HI) begin
			seq_d[63:32] = data_word;
		end
		pos_ext  = lfc_pkg::WORD_W'(pos_q);
		received = pos_ext + lfc_pkg::WORD_W'(1);
		// carried checksum word counts as zero
		term     = (pos_q == lfc_pkg::POS_CSUM) ? '0 : data_word;
		sum_d    = (pos_ext < len_d) ? ((sum_q + term) ^ term) : sum_q;
		too_long  = len_d > lfc_pkg::WORD_W'(lfc_pkg::MAX_FRAME_WORDS);
		too_short = received < len_d;

		rpt.checksum_bad      = too_long || too_short || (sum_d != carried_d);
		rpt.frame_length      = len_d;
		rpt.received_sequence = seq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			len_q     <= '0;
			carried_q <= '0;
			seq_q     <= '0;
		end else if (advance) begin
			if (frame_end) begin
				pos_q     <= '0;
				sum_q     <= '0;
				len_q     <= '0;
				carried_q <= '0;
				seq_q     <= '0;
			end else begin
				pos_q     <= (pos_q == lfc_pkg::POS_LIMIT) ? pos_q : pos_q + lfc_pkg::POS_W'(1);
				sum_q     <= sum_d;
				len_q     <= len_d;
				carried_q <= carried_d;
				seq_q     <= seq_d;
			end
		end
	end

`ifndef SYNTHESIS
	// a frame end always restarts the header capture
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && frame_end |=> pos_q == '0 && sum_q == '0)
		else $error("frame state not cleared after frame end");
	// position only moves on an advanced item
	a_pos_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pos_q))
		else $error("word position moved without an item");
	// once saturated, position stays until frame end
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == lfc_pkg::POS_LIMIT && !frame_end |=> pos_q == lfc_pkg::POS_LIMIT)
		else $error("saturated word position wrapped");
`endif

endmodule

FILE: src/loopback_frame_checker_top.sv
// loopback frame checker: input register, frame accumulator, totals and result register
// a frame-end item is taken into the input register; its report is loaded into the result register when it advances
// throughput: one word per cycle; the only stall is a frame end while an unread report is held
// ready follows the report side combinationally through the input register's advance
// reset: arst_n clears frame state, expected sequence, all totals and both valid flags
// no clearing pass: the block accepts words as soon as reset is released
module loopback_frame_checker_top (
	input  logic                clk,
	input  logic                arst_n,
	lfc_word_if.sink            words,
	lfc_report_if.source        report
);

	// input register
	logic        valid_s1;
	logic [31:0] data_word_s1;
	logic        frame_end_s1;

	// running totals and expected sequence
	logic [lfc_pkg::SEQ_W-1:0]   expected_seq_q;
	logic [lfc_pkg::TOTAL_W-1:0] csum_err_q;
	logic [lfc_pkg::TOTAL_W-1:0] seq_err_q;
	logic [lfc_pkg::TOTAL_W-1:0] good_words_q;

	// result register
	logic                        out_valid_q;
	logic                        out_csum_bad_q;
	logic                        out_seq_bad_q;
	logic [31:0]                 out_len_q;
	logic [63:0]                 out_seq_q;

	lfc_pkg::frame_rpt_t         rpt;
	logic                        stall;
	logic                        advance;
	logic                        load;
	logic                        seq_bad;
	logic [lfc_pkg::TOTAL_W-1:0] csum_err_d;
	logic [lfc_pkg::TOTAL_W-1:0] seq_err_d;
	logic [lfc_pkg::TOTAL_W-1:0] good_words_d;

	// a frame end can only leave the input register when the result slot is free or its report is being taken
	assign stall   = valid_s1 && frame_end_s1 && out_valid_q && !report.ready;
	assign advance = valid_s1 && !stall;
	assign load    = advance && frame_end_s1;
	assign words.ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.valid && words.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			data_word_s1 <= words.data_word;
			frame_end_s1 <= words.frame_end;
		end
	end

	lfc_frame_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_word (data_word_s1),
		.frame_end (frame_end_s1),
		.rpt       (rpt)
	);

	// totals after this frame's update
	always_comb begin
		seq_bad      = rpt.received_sequence != expected_seq_q;
		csum_err_d   = csum_err_q + lfc_pkg::TOTAL_W'(rpt.checksum_bad);
		seq_err_d    = seq_err_q + lfc_pkg::TOTAL_W'(seq_bad);
		good_words_d = rpt.checksum_bad ? good_words_q
			: good_words_q + lfc_pkg::TOTAL_W'(rpt.frame_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q <= '0;
			csum_err_q     <= '0;
			seq_err_q      <= '0;
			good_words_q   <= '0;
		end else if (load) begin
			expected_seq_q <= rpt.received_sequence + lfc_pkg::SEQ_W'(1);
			csum_err_q     <= csum_err_d;
			seq_err_q      <= seq_err_d;
			good_words_q   <= good_words_d;
		end
	end

	// result slot: filled on frame end, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_csum_bad_q <= rpt.checksum_bad;
			out_seq_bad_q  <= seq_bad;
			out_len_q      <= rpt.frame_length;
			out_seq_q      <= rpt.received_sequence;
		end
	end

	// totals registers double as the report's total fields
	assign report.valid                = out_valid_q;
	assign report.checksum_bad         = out_csum_bad_q;
	assign report.sequence_bad         = out_seq_bad_q;
	assign report.frame_length         = out_len_q;
	assign report.received_sequence    = out_seq_q;
	assign report.checksum_error_total = csum_err_q;
	assign report.sequence_error_total = seq_err_q;
	assign report.good_words_total     = good_words_q;

`ifndef SYNTHESIS
	// a new report only comes from a frame-end word
	a_rise_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && frame_end_s1))
		else $error("report raised without a frame end");
	// words are only held back by a frame end facing a full result slot
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!words.ready |-> valid_s1 && frame_end_s1 && out_valid_q)
		else $error("input stalled without cause");
	// error total steps by exactly the reported flag
	a_csum_total: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> csum_err_q == $past(csum_err_q) + lfc_pkg::TOTAL_W'(out_csum_bad_q))
		else $error("checksum error total out of step with flag");
	// totals never move between frame ends
	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(csum_err_q) && $stable(seq_err_q) && $stable(good_words_q))
		else $error("totals changed without a frame end");
`endif

endmodule
